// File: design/dspe_pkg.sv
// Shared constants, field layout and state type of the dense shortest path engine.
package dspe_pkg;

    // Default sizing of the engine.
    localparam int MAX_NODES_DEF   = 32;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int DIST_BITS_DEF   = 24;

    // Fixed field widths of the stream words.
    localparam int NODE_W    = 6;
    localparam int WEIGHT_W  = 16;
    localparam int PATH_W    = 24;
    localparam int CFG_W     = 6;

    // Input word layout (tdata), lowest bit first.
    localparam int IN_FROM_LSB   = 0;
    localparam int IN_TO_LSB     = IN_FROM_LSB + NODE_W;
    localparam int IN_WEIGHT_LSB = IN_TO_LSB + NODE_W;
    localparam int IN_START_LSB  = IN_WEIGHT_LSB + WEIGHT_W;
    localparam int IN_USED_W     = IN_START_LSB + NODE_W;
    localparam int S_TDATA_W     = ((IN_USED_W + 7) / 8) * 8;

    // Output word layout (tdata), lowest bit first.
    localparam int OUT_NODE_LSB  = 0;
    localparam int OUT_PATH_LSB  = OUT_NODE_LSB + NODE_W;
    localparam int OUT_USED_W    = OUT_PATH_LSB + PATH_W;
    localparam int M_TDATA_W     = ((OUT_USED_W + 7) / 8) * 8;

    // Node count after reset.
    localparam logic [CFG_W-1:0] NODE_COUNT_RESET = CFG_W'(32);

    // Command codes carried in the input tuser.
    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EDGE_A,
        S_EDGE_B,
        S_SCAN,
        S_PICK,
        S_RELAX,
        S_OUT_RD,
        S_OUT_WR
    } t_state;

endpackage

// File: design/dense_shortest_path_engine.sv
// Top level of the dense shortest path engine: sequencer, weight and distance memories.
//
//  channel  | direction | word contents (lowest bit first)                  | handshake
//  ---------+-----------+---------------------------------------------------+-----------
//  s_axis   | in        | tdata: from_node, to_node, edge_weight, start_node| tvalid/tready
//           |           | tuser: cmd                                        |
//  m_axis   | out       | tdata: node_index, path_length; tuser: reached    | tvalid/tready
//           |           | tlast: last                                       |
//  cfg      | in        | data: node_count                                  | valid/ready
//
// After reset the weight matrix is cleared one entry per cycle, 2^(2*ceil(log2(MAX_NODES)))
// entries in all (1024 for 32 nodes); no word is accepted until that pass ends.
// An edge word is handled as acceptance and then one write to each mirrored matrix cell.
// A run over N nodes makes up to N passes of a scan over the N nodes, a pick and a
// relaxation over the N nodes, then one last scan and pick, stepping one node at a time as
// set by the single shared add and compare unit and the one read port of each memory.
// Results then leave one word at a time; the output register holds a word while the sink
// stalls, and the engine returns to idle as soon as the last word is loaded.
module dense_shortest_path_engine #(
    parameter int MAX_NODES   = dspe_pkg::MAX_NODES_DEF,
    parameter int WEIGHT_BITS = dspe_pkg::WEIGHT_BITS_DEF,
    parameter int DIST_BITS   = dspe_pkg::DIST_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input words. tdata: from_node, to_node, edge_weight, start_node. tuser: cmd.
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [dspe_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    input  logic [0:0]                     i_s_axis_tuser,
    // Result words. tdata: node_index, path_length. tuser: reached.
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [dspe_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    output logic [0:0]                     o_m_axis_tuser,
    output logic                           o_m_axis_tlast,
    // Configuration write: node_count.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dspe_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int IDX_W       = $clog2(MAX_NODES);
    localparam int CNT_W       = $clog2(MAX_NODES + 1);
    localparam int WMEM_AW     = 2 * IDX_W;
    localparam int WMEM_DEPTH  = 1 << WMEM_AW;
    localparam int DMEM_DEPTH  = 1 << IDX_W;
    localparam int NODE_W      = dspe_pkg::NODE_W;

    // Input field extraction.
    logic [NODE_W-1:0]            s_from;
    logic [NODE_W-1:0]            s_to;
    logic [dspe_pkg::WEIGHT_W-1:0] s_weight;
    logic [NODE_W-1:0]            s_start;
    logic                         s_cmd;
    logic                         s_accept;

    assign s_from   = i_s_axis_tdata[dspe_pkg::IN_FROM_LSB +: NODE_W];
    assign s_to     = i_s_axis_tdata[dspe_pkg::IN_TO_LSB +: NODE_W];
    assign s_weight = i_s_axis_tdata[dspe_pkg::IN_WEIGHT_LSB +: dspe_pkg::WEIGHT_W];
    assign s_start  = i_s_axis_tdata[dspe_pkg::IN_START_LSB +: NODE_W];
    assign s_cmd    = i_s_axis_tuser[0];

    // Control and datapath registers.
    dspe_pkg::t_state        r_state, n_state;
    logic [WMEM_AW-1:0]      r_clr, n_clr;
    logic [dspe_pkg::CFG_W-1:0] r_node_count;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [IDX_W-1:0]        r_from, n_from;
    logic [IDX_W-1:0]        r_to, n_to;
    logic [WEIGHT_BITS-1:0]  r_w, n_w;
    logic [MAX_NODES-1:0]    r_reach, n_reach;
    logic [MAX_NODES-1:0]    r_fin, n_fin;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic                    r_pv, n_pv;
    logic [IDX_W-1:0]        r_pidx, n_pidx;
    logic                    r_found, n_found;
    logic [IDX_W-1:0]        r_u, n_u;
    logic [DIST_BITS-1:0]    r_best, n_best;
    logic                    r_out_valid, n_out_valid;
    logic [NODE_W-1:0]       r_out_node, n_out_node;
    logic [dspe_pkg::PATH_W-1:0] r_out_len, n_out_len;
    logic                    r_out_reach, n_out_reach;
    logic                    r_out_last, n_out_last;

    // Weight matrix memory: row is the first node, column the second, both zero based.
    logic [WEIGHT_BITS-1:0]  r_wmem [WMEM_DEPTH];
    logic [WEIGHT_BITS-1:0]  r_wmem_rd;
    logic                    wmem_we;
    logic [WMEM_AW-1:0]      wmem_waddr;
    logic [WEIGHT_BITS-1:0]  wmem_wdata;
    logic [WMEM_AW-1:0]      wmem_raddr;

    // Best distance memory; an entry is meaningful only where its reached bit is set.
    logic [DIST_BITS-1:0]    r_dmem [DMEM_DEPTH];
    logic [DIST_BITS-1:0]    r_dmem_rd;
    logic                    dmem_we;
    logic [IDX_W-1:0]        dmem_waddr;
    logic [DIST_BITS-1:0]    dmem_wdata;
    logic [IDX_W-1:0]        dmem_raddr;

    // Shared unit operands and results.
    logic [DIST_BITS-1:0]    alu_base;
    logic [WEIGHT_BITS-1:0]  alu_add;
    logic [DIST_BITS-1:0]    alu_ref;
    logic [DIST_BITS-1:0]    alu_sum;
    logic                    alu_less;

    // Helpers.
    logic [CNT_W-1:0]        run_cnt;
    logic [NODE_W-1:0]       start_m1;
    logic [NODE_W-1:0]       from_m1;
    logic [NODE_W-1:0]       to_m1;
    logic [CNT_W:0]          idx_p1;
    logic                    issue;
    logic                    out_load;

    assign start_m1 = s_start - NODE_W'(1);
    assign from_m1  = s_from - NODE_W'(1);
    assign to_m1    = s_to - NODE_W'(1);
    assign idx_p1   = {1'b0, r_idx} + (CNT_W+1)'(1);
    assign issue    = (r_idx < r_cnt);

    // A node count above the matrix size acts as the matrix size.
    assign run_cnt = (int'(r_node_count) > MAX_NODES) ? CNT_W'(MAX_NODES)
                                                      : CNT_W'(r_node_count);

    assign o_s_axis_tready = (r_state == dspe_pkg::S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // The scan compares a stored distance against the running minimum; the relaxation
    // adds the edge weight to the picked node's distance and compares with the neighbor.
    assign alu_base = (r_state == dspe_pkg::S_RELAX) ? r_best : r_dmem_rd;
    assign alu_add  = (r_state == dspe_pkg::S_RELAX) ? r_wmem_rd : '0;
    assign alu_ref  = (r_state == dspe_pkg::S_RELAX) ? r_dmem_rd : r_best;

    dspe_alu #(
        .DIST_BITS   (DIST_BITS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_alu (
        .i_base (alu_base),
        .i_add  (alu_add),
        .i_ref  (alu_ref),
        .o_sum  (alu_sum),
        .o_less (alu_less)
    );

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= dspe_pkg::NODE_COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_node_count <= i_cfg_data;
        end
    end

    // Memories with registered read data.
    always_ff @(posedge i_clk) begin
        if (wmem_we) begin
            r_wmem[wmem_waddr] <= wmem_wdata;
        end
        r_wmem_rd <= r_wmem[wmem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (dmem_we) begin
            r_dmem[dmem_waddr] <= dmem_wdata;
        end
        r_dmem_rd <= r_dmem[dmem_raddr];
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dspe_pkg::S_CLEAR;
            r_clr       <= '0;
            r_reach     <= '0;
            r_fin       <= '0;
            r_idx       <= '0;
            r_pv        <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_reach     <= n_reach;
            r_fin       <= n_fin;
            r_idx       <= n_idx;
            r_pv        <= n_pv;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_from      <= n_from;
        r_to        <= n_to;
        r_w         <= n_w;
        r_pidx      <= n_pidx;
        r_u         <= n_u;
        r_best      <= n_best;
        r_out_node  <= n_out_node;
        r_out_len   <= n_out_len;
        r_out_reach <= n_out_reach;
        r_out_last  <= n_out_last;
    end

    // Next state and memory controls.
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_cnt       = r_cnt;
        n_from      = r_from;
        n_to        = r_to;
        n_w         = r_w;
        n_reach     = r_reach;
        n_fin       = r_fin;
        n_idx       = r_idx;
        n_pv        = r_pv;
        n_pidx      = r_pidx;
        n_found     = r_found;
        n_u         = r_u;
        n_best      = r_best;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_node  = r_out_node;
        n_out_len   = r_out_len;
        n_out_reach = r_out_reach;
        n_out_last  = r_out_last;
        out_load    = 1'b0;

        wmem_we    = 1'b0;
        wmem_waddr = {r_from, r_to};
        wmem_wdata = r_w;
        wmem_raddr = {r_u, r_idx[IDX_W-1:0]};
        dmem_we    = 1'b0;
        dmem_waddr = r_pidx;
        dmem_wdata = alu_sum;
        dmem_raddr = r_idx[IDX_W-1:0];

        unique case (r_state)
            dspe_pkg::S_CLEAR: begin
                wmem_we    = 1'b1;
                wmem_waddr = r_clr;
                wmem_wdata = '0;
                n_clr      = r_clr + WMEM_AW'(1);
                if (r_clr == {WMEM_AW{1'b1}}) begin
                    n_state = dspe_pkg::S_IDLE;
                end
            end

            dspe_pkg::S_IDLE: begin
                if (s_accept) begin
                    if (s_cmd == dspe_pkg::CMD_EDGE) begin
                        n_from = from_m1[IDX_W-1:0];
                        n_to   = to_m1[IDX_W-1:0];
                        n_w    = WEIGHT_BITS'(s_weight);
                        // Ends outside the matrix make the edge word do nothing.
                        if (s_from != '0 && int'(s_from) <= MAX_NODES &&
                            s_to != '0 && int'(s_to) <= MAX_NODES) begin
                            n_state = dspe_pkg::S_EDGE_A;
                        end
                    end else begin
                        n_cnt   = run_cnt;
                        n_reach = '0;
                        n_fin   = '0;
                        n_idx   = '0;
                        n_pv    = 1'b0;
                        n_found = 1'b0;
                        if (run_cnt == '0) begin
                            n_state = dspe_pkg::S_IDLE;
                        end else if (s_start != '0 && int'(s_start) <= int'(run_cnt)) begin
                            n_reach[start_m1[IDX_W-1:0]] = 1'b1;
                            dmem_we    = 1'b1;
                            dmem_waddr = start_m1[IDX_W-1:0];
                            dmem_wdata = '0;
                            n_state    = dspe_pkg::S_SCAN;
                        end else begin
                            // Start node out of range: every node reports unreached.
                            n_state = dspe_pkg::S_OUT_RD;
                        end
                    end
                end
            end

            dspe_pkg::S_EDGE_A: begin
                wmem_we    = 1'b1;
                wmem_waddr = {r_from, r_to};
                n_state    = dspe_pkg::S_EDGE_B;
            end

            dspe_pkg::S_EDGE_B: begin
                wmem_we    = 1'b1;
                wmem_waddr = {r_to, r_from};
                n_state    = dspe_pkg::S_IDLE;
            end

            dspe_pkg::S_SCAN: begin
                n_pv = issue;
                if (issue) begin
                    n_idx  = idx_p1[CNT_W-1:0];
                    n_pidx = r_idx[IDX_W-1:0];
                end
                // Strict compare keeps the lowest index on ties.
                if (r_pv && r_reach[r_pidx] && !r_fin[r_pidx] && (!r_found || alu_less)) begin
                    n_found = 1'b1;
                    n_u     = r_pidx;
                    n_best  = r_dmem_rd;
                end
                if (!issue && r_pv) begin
                    n_state = dspe_pkg::S_PICK;
                end
            end

            dspe_pkg::S_PICK: begin
                n_idx = '0;
                n_pv  = 1'b0;
                if (r_found) begin
                    n_fin[r_u] = 1'b1;
                    n_state    = dspe_pkg::S_RELAX;
                end else begin
                    n_state = dspe_pkg::S_OUT_RD;
                end
            end

            dspe_pkg::S_RELAX: begin
                n_pv = issue;
                if (issue) begin
                    n_idx  = idx_p1[CNT_W-1:0];
                    n_pidx = r_idx[IDX_W-1:0];
                end
                if (r_pv && !r_fin[r_pidx] && r_wmem_rd != '0 &&
                    (!r_reach[r_pidx] || alu_less)) begin
                    dmem_we          = 1'b1;
                    n_reach[r_pidx]  = 1'b1;
                end
                if (!issue && r_pv) begin
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_state = dspe_pkg::S_SCAN;
                end
            end

            dspe_pkg::S_OUT_RD: begin
                n_state = dspe_pkg::S_OUT_WR;
            end

            dspe_pkg::S_OUT_WR: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_node  = NODE_W'(idx_p1);
                    n_out_reach = r_reach[r_idx[IDX_W-1:0]];
                    n_out_len   = r_reach[r_idx[IDX_W-1:0]]
                                ? dspe_pkg::PATH_W'(r_dmem_rd)
                                : dspe_pkg::PATH_W'({DIST_BITS{1'b1}});
                    n_out_last  = (idx_p1 == {1'b0, r_cnt});
                    n_idx       = idx_p1[CNT_W-1:0];
                    n_state     = (idx_p1 == {1'b0, r_cnt}) ? dspe_pkg::S_IDLE
                                                            : dspe_pkg::S_OUT_RD;
                end
            end

            default: begin
                n_state = dspe_pkg::S_IDLE;
            end
        endcase
    end

    // Result word.
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = dspe_pkg::M_TDATA_W'({r_out_len, r_out_node});
    assign o_m_axis_tuser  = r_out_reach;
    assign o_m_axis_tlast  = r_out_last;

    // A relaxation never rewrites the distance of a finished node.
    a_relax_unfinished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dmem_we && r_state == dspe_pkg::S_RELAX) |-> !r_fin[dmem_waddr])
        else $error("distance write to a finished node");

    // The picked node is reached and not yet finished.
    a_pick_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dspe_pkg::S_PICK && r_found) |-> (r_reach[r_u] && !r_fin[r_u]))
        else $error("scan picked an ineligible node");

    // A new result word appears only from the result stage.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == dspe_pkg::S_OUT_WR))
        else $error("result word loaded outside the result stage");

    // No word is accepted while the matrix is being cleared.
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dspe_pkg::S_CLEAR) |-> !s_accept)
        else $error("word accepted during the clearing pass");

    // A result is loaded only into a free or draining output register.
    a_out_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || i_m_axis_tready))
        else $error("result word overwritten before it was taken");

endmodule

// File: design/dspe_alu.sv
// Shared saturating add and compare unit used by the minimum scan and the relaxation.
module dspe_alu #(
    parameter int DIST_BITS   = dspe_pkg::DIST_BITS_DEF,
    parameter int WEIGHT_BITS = dspe_pkg::WEIGHT_BITS_DEF
) (
    input  logic [DIST_BITS-1:0]   i_base,
    input  logic [WEIGHT_BITS-1:0] i_add,
    input  logic [DIST_BITS-1:0]   i_ref,
    output logic [DIST_BITS-1:0]   o_sum,
    output logic                   o_less
);

    localparam int SUM_W = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;

    logic [SUM_W-1:0] sum;

    // The sum saturates at the all-ones distance.
    assign sum    = SUM_W'(i_base) + SUM_W'(i_add);
    assign o_sum  = (|sum[SUM_W-1:DIST_BITS]) ? {DIST_BITS{1'b1}} : sum[DIST_BITS-1:0];
    assign o_less = (o_sum < i_ref);

endmodule

// File: dv/path_length_checker.sv
// Stream monitor that predicts the per-node shortest path words and checks them.
`timescale 1ns / 100ps

module path_length_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input stream of the engine, observed only.
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [dspe_pkg::S_TDATA_W-1:0] i_in_data,
    input  logic [0:0]                     i_in_user,
    // Result stream of the engine, observed only.
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [dspe_pkg::M_TDATA_W-1:0] i_out_data,
    input  logic [0:0]                     i_out_user,
    input  logic                           i_out_last,
    // Node count register write channel.
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [dspe_pkg::CFG_W-1:0]     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_reports
);

    localparam int NODES    = dspe_pkg::MAX_NODES_DEF;
    localparam int NODE_W   = dspe_pkg::NODE_W;
    localparam int PATH_W   = dspe_pkg::PATH_W;
    localparam int WEIGHT_W = dspe_pkg::WEIGHT_W;
    localparam int CFG_W    = dspe_pkg::CFG_W;
    localparam logic [PATH_W-1:0] FAR = '1;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [PATH_W-1:0] length;
        logic              reached;
        logic              last;
    } t_node_report;

    logic [WEIGHT_W-1:0] edge_weights [NODES][NODES];
    logic [CFG_W-1:0]    node_limit;
    t_node_report        due_results [$];
    int                  miss_count = 0;
    int                  report_count = 0;

    // Dijkstra with a linear minimum scan; the lowest index wins a tie.
    function automatic void predict_paths(input logic [NODE_W-1:0] start);
        logic [PATH_W-1:0] path_len [NODES];
        bit                seen [NODES];
        bit                done [NODES];
        logic [PATH_W:0]   sum;
        logic [PATH_W-1:0] cand;
        t_node_report      rep;
        int                count;
        int                u;
        bit                found;
        count = (node_limit > NODES) ? NODES : int'(node_limit);
        for (int i = 0; i < NODES; i++) begin
            path_len[i] = FAR;
            seen[i] = 1'b0;
            done[i] = 1'b0;
        end
        if (start >= 1 && start <= count) begin
            path_len[start - 1] = '0;
            seen[start - 1] = 1'b1;
        end
        do begin
            found = 1'b0;
            u = 0;
            for (int i = 0; i < count; i++) begin
                if (seen[i] && !done[i] && (!found || path_len[i] < path_len[u])) begin
                    u = i;
                    found = 1'b1;
                end
            end
            if (found) begin
                done[u] = 1'b1;
                for (int v = 0; v < count; v++) begin
                    if (!done[v] && edge_weights[u][v] != '0) begin
                        sum = {1'b0, path_len[u]} + (PATH_W+1)'(edge_weights[u][v]);
                        cand = sum[PATH_W] ? FAR : sum[PATH_W-1:0];
                        if (!seen[v] || cand < path_len[v]) begin
                            path_len[v] = cand;
                            seen[v] = 1'b1;
                        end
                    end
                end
            end
        end while (found);
        for (int i = 0; i < count; i++) begin
            rep.node    = NODE_W'(i + 1);
            rep.length  = seen[i] ? path_len[i] : FAR;
            rep.reached = seen[i];
            rep.last    = (i + 1 == count);
            due_results.push_back(rep);
        end
    endfunction

    always @(posedge i_clk) begin
        t_node_report        want;
        t_node_report        got;
        logic [NODE_W-1:0]   end_a;
        logic [NODE_W-1:0]   end_b;
        logic [WEIGHT_W-1:0] new_w;
        if (!i_rst_n) begin
            for (int i = 0; i < NODES; i++) begin
                for (int j = 0; j < NODES; j++) begin
                    edge_weights[i][j] = '0;
                end
            end
            node_limit = dspe_pkg::NODE_COUNT_RESET;
            due_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                node_limit = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_user[0] == dspe_pkg::CMD_EDGE) begin
                    end_a = i_in_data[dspe_pkg::IN_FROM_LSB +: NODE_W];
                    end_b = i_in_data[dspe_pkg::IN_TO_LSB +: NODE_W];
                    new_w = i_in_data[dspe_pkg::IN_WEIGHT_LSB +: WEIGHT_W];
                    if (end_a >= 1 && end_a <= NODES && end_b >= 1 && end_b <= NODES) begin
                        edge_weights[end_a - 1][end_b - 1] = new_w;
                        edge_weights[end_b - 1][end_a - 1] = new_w;
                    end
                end else begin
                    predict_paths(i_in_data[dspe_pkg::IN_START_LSB +: NODE_W]);
                end
            end
            if (i_out_valid && i_out_ready) begin
                got.node    = i_out_data[dspe_pkg::OUT_NODE_LSB +: NODE_W];
                got.length  = i_out_data[dspe_pkg::OUT_PATH_LSB +: PATH_W];
                got.reached = i_out_user[0];
                got.last    = i_out_last;
                if (due_results.size() == 0) begin
                    miss_count++;
                    if (miss_count <= 10) begin
                        $display("%0t: unexpected word: node %0d length %0d %s %0b %s %0b",
                                 $realtime, got.node, got.length, "reached", got.reached,
                                 "last", got.last);
                    end
                end else begin
                    want = due_results.pop_front();
                    report_count++;
                    if (got !== want) begin
                        miss_count++;
                        if (miss_count <= 10) begin
                            $display("%0t: word mismatch: expected node %0d length %0d %s",
                                     $realtime, want.node, want.length,
                                     $sformatf("reached %0b last %0b", want.reached,
                                               want.last));
                            $display("    got node %0d length %0d reached %0b last %0b",
                                     got.node, got.length, got.reached, got.last);
                        end
                    end
                end
            end
        end
        o_pending    <= due_results.size();
        o_fail_count <= miss_count;
        o_reports    <= report_count;
    end

endmodule

// File: dv/dense_shortest_path_engine_test.sv
// Top of the shortest path engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module dense_shortest_path_engine_test;

    localparam int S_TDATA_W = dspe_pkg::S_TDATA_W;
    localparam int M_TDATA_W = dspe_pkg::M_TDATA_W;
    localparam int CFG_W     = dspe_pkg::CFG_W;
    localparam int NODE_W    = dspe_pkg::NODE_W;
    localparam int WEIGHT_W  = dspe_pkg::WEIGHT_W;
    localparam int MAX_NODES = dspe_pkg::MAX_NODES_DEF;

    // A long receiver hold lets the engine fill its output register and stall its input.
    localparam int HOLD_CYCLES   = 1500;
    // Edge words are still being written after acceptance and produce no word, and a run with
    // a node count of zero produces none either, so idle checks leave a safety margin.
    localparam int SETTLE_CYCLES = 80;
    // The final drain covers one full 32 node run.
    localparam int DRAIN_CYCLES  = 2500;
    localparam int PHASES        = 10;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;

    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0]           s_tuser = '0;

    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;
    logic                 m_tlast;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Pacing knobs: percent chance per cycle that the sender idles or the sink stalls.
    int                   send_idle_pct = 0;
    int                   stall_pct = 0;
    logic                 hold_req = 1'b0;
    int                   hold_left = 0;

    int                   fail_count;
    int                   pending;
    int                   reports;
    int                   edges_sent = 0;
    int                   runs_sent = 0;

    // Node count and item count of each random phase; the extremes and the out of range
    // counts (zero gives no words, 63 behaves as 32) are all visited.
    int                   phase_counts [PHASES] = '{1, 5, 9, 32, 3, 0, 63, 16, 2, 7};
    int                   phase_items  [PHASES] = '{20, 35, 35, 18, 30, 10, 12, 35, 30, 35};

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    dense_shortest_path_engine dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    path_length_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (s_tvalid),
        .i_in_ready   (s_tready),
        .i_in_data    (s_tdata),
        .i_in_user    (s_tuser),
        .i_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .i_out_data   (m_tdata),
        .i_out_user   (m_tuser),
        .i_out_last   (m_tlast),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_reports    (reports)
    );

    // Result sink. It stalls at random per cycle, and a hold request blocks it outright
    // until a countdown from HOLD_CYCLES, kept here, runs out.
    always @(posedge clk) begin
        if (hold_req) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
        m_tready <= !hold_req && hold_left == 0 && ($urandom_range(99) >= stall_pct);
    end

    // Offers one word and returns at the edge where it is taken. Valid stays high
    // afterwards, so back to back words keep it high without a glitch; whoever stops
    // sending must lower it.
    task automatic push_word(input logic cmd, input logic [NODE_W-1:0] from_n,
                             input logic [NODE_W-1:0] to_n, input logic [WEIGHT_W-1:0] weight,
                             input logic [NODE_W-1:0] start_n);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[dspe_pkg::IN_FROM_LSB +: NODE_W]     = from_n;
        word[dspe_pkg::IN_TO_LSB +: NODE_W]       = to_n;
        word[dspe_pkg::IN_WEIGHT_LSB +: WEIGHT_W] = weight;
        word[dspe_pkg::IN_START_LSB +: NODE_W]    = start_n;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (cmd == dspe_pkg::CMD_RUN) runs_sent++;
        else edges_sent++;
    endtask

    // The fields that a command ignores carry random junk.
    task automatic send_edge(input logic [NODE_W-1:0] from_n, input logic [NODE_W-1:0] to_n,
                             input logic [WEIGHT_W-1:0] weight);
        push_word(dspe_pkg::CMD_EDGE, from_n, to_n, weight, NODE_W'($urandom));
    endtask

    task automatic send_run(input logic [NODE_W-1:0] start_n);
        push_word(dspe_pkg::CMD_RUN, NODE_W'($urandom), NODE_W'($urandom),
                  WEIGHT_W'($urandom), start_n);
    endtask

    // Stops sending and waits until every predicted word has come back, then lets any
    // trailing edge write or empty run finish inside the engine.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_node_count(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly nodes in use, so random graphs stay connected enough to matter; some ends
    // land on nodes above the count, and a few anywhere in the field including 0 and 63.
    function automatic logic [NODE_W-1:0] pick_node(input int active);
        int roll;
        roll = $urandom_range(99);
        if (roll < 85) return NODE_W'($urandom_range(active, 1));
        if (roll < 93) return NODE_W'($urandom_range(MAX_NODES, 1));
        return NODE_W'($urandom_range(63, 0));
    endfunction

    // Run limit, far above the slowest legal run.
    initial begin
        #40_000_000;
        $display("dense_shortest_path_engine_test: errors");
        $finish;
    end

    initial begin
        int                  active;
        int                  mode;
        int                  roll;
        logic [WEIGHT_W-1:0] weight;
        logic [NODE_W-1:0]   end_a;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset node count of 32. The engine clears its matrix first
        // and holds tready low meanwhile, which the handshake absorbs.
        send_edge(1, 2, 5);
        send_edge(2, 3, 7);
        // A direct edge that loses to the two hop path through node 2.
        send_edge(1, 3, 20);
        // Self loop on the diagonal, which a run must ignore.
        send_edge(3, 3, 9);
        // Ends of zero and above the node range are dropped.
        send_edge(0, 4, 3);
        send_edge(4, 63, 3);
        // Largest weights on the highest nodes give the longest distances.
        send_edge(32, 31, 16'hFFFF);
        send_edge(31, 3, 16'hFFFF);
        send_edge(4, 5, 6);
        send_edge(1, 4, 6);
        // Nodes 2 and 6 tie at distance 5, so the scan must take the lower index first.
        send_edge(1, 6, 5);
        send_run(1);
        // A zero weight removes an edge; node 3 now falls back to the direct edge.
        send_edge(2, 3, 0);
        send_run(3);
        send_run(32);
        // A start of zero or above the node count leaves every node unreached.
        send_run(0);
        send_run(63);

        // Random part: each phase sets a node count and one pacing mode, rotating through
        // free flow, a lazy sender, a stalling sink and light idling on both sides.
        for (int p = 0; p < PHASES; p++) begin
            write_node_count(CFG_W'(phase_counts[p]));
            mode = p % 4;
            send_idle_pct = (mode == 1) ? 70 : (mode == 3) ? 10 : 0;
            stall_pct    <= (mode == 2) ? 70 : (mode == 3) ? 10 : 0;
            active = (phase_counts[p] == 0) ? 1 :
                     (phase_counts[p] > MAX_NODES) ? MAX_NODES : phase_counts[p];
            repeat (phase_items[p]) begin
                roll = $urandom_range(99);
                if (roll < 10) weight = '0;
                else if (roll < 30) weight = WEIGHT_W'($urandom);
                else weight = WEIGHT_W'($urandom_range(20, 1));
                if ($urandom_range(99) < 30) begin
                    send_run(pick_node(active));
                end else begin
                    end_a = pick_node(active);
                    send_edge(end_a, pick_node(active), weight);
                end
            end
        end

        // Backpressure: the sink blocks for a long stretch while runs keep coming, so the
        // engine parks a word in its output register and stops taking input.
        write_node_count(CFG_W'(6));
        send_idle_pct = 0;
        stall_pct    <= 0;
        hold_req     <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        repeat (8) send_run(pick_node(6));

        // Drain, then watch for stray words long enough for a full run.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d edge writes and %0d runs over node counts 0 to 63 with mixed pacing.",
                 edges_sent, runs_sent);
        $display("Checked %0d per-node distance words; %0d still outstanding.", reports, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("dense_shortest_path_engine_test: clean");
        end else begin
            $display("dense_shortest_path_engine_test: errors");
        end
        $finish;
    end

endmodule

// File: files.f
design/dspe_pkg.sv
design/dspe_alu.sv
design/dense_shortest_path_engine.sv
dv/path_length_checker.sv
dv/dense_shortest_path_engine_test.sv
